// ===== rtl/core/arel_pkg.sv =====
// ----------------------------------------------------------------------------
// arel_pkg
// Shared types and constants for the acknowledged event ring.
// ----------------------------------------------------------------------------
package arel_pkg;

  // Default ring depth
  localparam int DEPTH_DEF = 4;

  // Field widths
  localparam int CMD_W = 2;
  localparam int CAT_W = 3;
  localparam int SEQ_W = 32;
  localparam int TIME_W = 32;

  // Stream word widths (packed fields, padded to whole bytes)
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 72;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd2;

  // One stored entry (sent mark lives in flops outside the memory)
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] stamp;
    logic [CAT_W-1:0] cat;
  } entry_t;

  // One peek result
  typedef struct packed {
    logic found;
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] stamp;
    logic [CAT_W-1:0] cat;
  } result_t;

endpackage

// ===== rtl/core/arel_entry_ram.sv =====
// ----------------------------------------------------------------------------
// arel_entry_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arel_entry_ram #(
  parameter int DEPTH = arel_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  arel_pkg::entry_t     wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output arel_pkg::entry_t     rd_data
);
  import arel_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/arel_out_reg.sv =====
// ----------------------------------------------------------------------------
// arel_out_reg
// Output word register: holds one peek result until the receiver takes it.
// ----------------------------------------------------------------------------
module arel_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  arel_pkg::result_t   res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output arel_pkg::result_t   out_res
);
  import arel_pkg::*;

  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= res;
    end
  end

endmodule

// ===== rtl/core/arel_ctrl.sv =====
// ----------------------------------------------------------------------------
// arel_ctrl
// Command sequencer: ring pointers, sent marks and the scan over the memory.
// ----------------------------------------------------------------------------
module arel_ctrl #(
  parameter int DEPTH = arel_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arel_pkg::CMD_W-1:0]    cmd,
  input  logic [arel_pkg::CAT_W-1:0]    cat,
  input  logic [arel_pkg::TIME_W-1:0]   stamp,
  input  logic [arel_pkg::SEQ_W-1:0]    seq_req,
  // memory side
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output arel_pkg::entry_t              wr_data,
  output logic [IDX_W-1:0]              rd_addr,
  input  arel_pkg::entry_t              rd_data,
  // result side
  input  logic                          res_free,
  output logic                          res_push,
  output arel_pkg::result_t             res
);
  import arel_pkg::*;

  localparam int SW = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  // State codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PEEK_SCAN = 3'd1;
  localparam logic [2:0] ST_PEEK_RD = 3'd2;
  localparam logic [2:0] ST_PEEK_OUT = 3'd3;
  localparam logic [2:0] ST_MARK_RD = 3'd4;
  localparam logic [2:0] ST_MARK_CMP = 3'd5;

  logic [2:0] state;
  logic [DEPTH-1:0] done;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] fill;
  logic [SEQ_W-1:0] issued;
  logic [IDX_W-1:0] ptr;
  logic [CNT_W-1:0] cnt;
  logic [SEQ_W-1:0] req;
  logic accept;
  logic [SW-1:0] start_sum;
  logic [IDX_W-1:0] start_idx;
  logic [IDX_W-1:0] ptr_next;
  logic [IDX_W-1:0] head_next;
  logic [SEQ_W-1:0] issued_next;

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;

  // Oldest slot: (head - fill) mod DEPTH
  assign start_sum = SW'(head) + DEPTH_S - SW'(fill);
  assign start_idx = (start_sum >= DEPTH_S) ? IDX_W'(start_sum - DEPTH_S)
                                            : IDX_W'(start_sum);

  assign ptr_next = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
  assign head_next = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign issued_next = issued + 1'b1;

  // Record writes go straight into the memory at the head
  assign wr_en = accept && (cmd == CMD_RECORD);
  assign wr_addr = head;
  assign wr_data = '{seq: issued_next, stamp: stamp, cat: cat};
  assign rd_addr = ptr;

  assign res_push = (state == ST_PEEK_OUT) && res_free;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= '1;
      head <= '0;
      fill <= '0;
      issued <= '0;
      ptr <= '0;
      cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_RECORD: begin
                done[head] <= 1'b0;
                head <= head_next;
                issued <= issued_next;
                if (fill != FULL_CNT) begin
                  fill <= fill + 1'b1;
                end
              end
              CMD_PEEK: begin
                ptr <= start_idx;
                cnt <= '0;
                state <= (fill == '0) ? ST_PEEK_OUT : ST_PEEK_SCAN;
              end
              CMD_MARK: begin
                ptr <= '0;
                state <= ST_MARK_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PEEK_SCAN: begin
          // read is issued at ptr this cycle
          if (!done[ptr]) begin
            state <= ST_PEEK_RD;
          end else if (cnt + 1'b1 == fill) begin
            state <= ST_PEEK_OUT;
          end else begin
            cnt <= cnt + 1'b1;
            ptr <= ptr_next;
          end
        end
        ST_PEEK_RD: begin
          state <= ST_PEEK_OUT;
        end
        ST_PEEK_OUT: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        ST_MARK_RD: begin
          // skip slots already sent
          if (!done[ptr]) begin
            state <= ST_MARK_CMP;
          end else if (ptr == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            ptr <= ptr_next;
          end
        end
        ST_MARK_CMP: begin
          if (rd_data.seq == req) begin
            done[ptr] <= 1'b1;
            state <= ST_IDLE;
          end else if (ptr == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            ptr <= ptr_next;
            state <= ST_MARK_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= seq_req;
      res <= '0;
    end
    if (state == ST_PEEK_RD) begin
      res <= '{found: 1'b1, seq: rd_data.seq, stamp: rd_data.stamp, cat: rd_data.cat};
    end
  end

endmodule

// ===== rtl/core/ack_ring_event_log_top.sv =====
// ----------------------------------------------------------------------------
// ack_ring_event_log_top
// Ring of event entries with per-entry sent marks.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on the s_ group. Command record stores an entry at
//   the head with the next sequence number (from 1) and overwrites the oldest
//   entry when the ring is full. Command peek returns one word on the m_
//   group: the oldest unsent entry, or all zero when there is none. Command
//   mark sets the sent mark of the lowest slot holding that unsent sequence.
//   Record and mark give no output word; code three is ignored.
// Timing:
//   One command at a time. Peek scans the sent-mark flops one slot a cycle
//   from the oldest entry and stops at the first unsent slot or after fill
//   slots; an unsent slot then costs one memory read. The result is
//   registered, then loaded into the output word register once that is
//   free. Mark scans from slot 0: each unsent slot costs one read and one
//   compare.
// Reset:
//   Synchronous; empties the ring, marks all slots sent, clears the counter.
// Stall:
//   A held output word blocks only the next peek result; s_tready returns
//   once the command in progress is done.
// ----------------------------------------------------------------------------
module ack_ring_event_log_top #(
  parameter int DEPTH = arel_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] category, [34:3] timestamp, [66:35] sequence_req, rest zero
  input  logic [arel_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] command
  input  logic [arel_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] entry_sequence, [63:32] entry_time, [66:64] entry_category, rest zero
  output logic [arel_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] found
  output logic                              m_tuser
);
  import arel_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OUT_USED = SEQ_W + TIME_W + CAT_W;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t rd_data;
  logic res_free;
  logic res_push;
  result_t res;
  result_t out_res;

  // Entry memory
  arel_entry_ram #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Command sequencer
  arel_ctrl #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .cmd(s_tuser),
    .cat(s_tdata[CAT_W-1:0]),
    .stamp(s_tdata[CAT_W+TIME_W-1:CAT_W]),
    .seq_req(s_tdata[CAT_W+TIME_W+SEQ_W-1:CAT_W+TIME_W]),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res_free(res_free),
    .res_push(res_push),
    .res(res)
  );

  // Output word register
  arel_out_reg u_out (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .res(res),
    .free(res_free),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res(out_res)
  );

  // Pack output word
  assign m_tdata = {{(OUT_DATA_W - OUT_USED){1'b0}}, out_res.cat, out_res.stamp, out_res.seq};
  assign m_tuser = out_res.found;

endmodule

// ===== sim/tb_ack_ring_event_log_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ack_ring_event_log_top
// Self-checking bench for the acknowledged event ring. A directed opener
// covers the empty ring, overwrite on a full ring, ignored code three, wide
// categories and marks that miss. Random command streams follow, mostly
// record/peek/mark-the-oldest runs with noise mixed in. The bench runs them
// under several idle and stall mixes. A shadow ring predicts every peek word.
// ----------------------------------------------------------------------------
module tb_ack_ring_event_log_top;
  import arel_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int WATCHDOG    = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 105;
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int src_idle_pct;
  int snk_stall_pct;
  bit hold_req;

  // Shadow ring: tracks entries and sent marks, queues predicted peek words
  class ring_scoreboard;
    logic [SEQ_W-1:0]  slot_seq [DEPTH];
    logic [TIME_W-1:0] slot_stamp [DEPTH];
    logic [CAT_W-1:0]  slot_cat [DEPTH];
    bit                slot_sent [DEPTH];
    int unsigned       head;
    int unsigned       fill;
    logic [SEQ_W-1:0]  seq_count;
    result_t           peek_q [$];
    int                errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_seq[i]   = '0;
        slot_stamp[i] = '0;
        slot_cat[i]   = 3'd4;
        slot_sent[i]  = 1'b1;
      end
      head      = 0;
      fill      = 0;
      seq_count = '0;
      errors    = 0;
    endfunction

    // Oldest unsent entry in ring order, all zero if none
    function result_t oldest_unsent();
      result_t     r;
      int unsigned idx;
      r = '0;
      for (int i = 0; i < fill; i++) begin
        idx = (head + DEPTH - fill + i) % DEPTH;
        if (!slot_sent[idx]) begin
          r.found = 1'b1;
          r.seq   = slot_seq[idx];
          r.stamp = slot_stamp[idx];
          r.cat   = slot_cat[idx];
          return r;
        end
      end
      return r;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [CAT_W-1:0] cat,
                               logic [TIME_W-1:0] stamp, logic [SEQ_W-1:0] seq_req);
      case (cmd)
        CMD_RECORD: begin
          seq_count        = seq_count + 1;
          slot_seq[head]   = seq_count;
          slot_stamp[head] = stamp;
          slot_cat[head]   = cat;
          slot_sent[head]  = 1'b0;
          head             = (head + 1) % DEPTH;
          if (fill < DEPTH) fill++;
        end
        CMD_PEEK: begin
          peek_q.push_back(oldest_unsent());
        end
        CMD_MARK: begin
          // lowest slot index wins
          for (int i = 0; i < DEPTH; i++) begin
            if (slot_seq[i] == seq_req && !slot_sent[i]) begin
              slot_sent[i] = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic found, logic [OUT_DATA_W-1:0] data);
      result_t want;
      if (peek_q.size() == 0) begin
        $error("unexpected output word: found=%0b data=%h", found, data);
        errors++;
        return;
      end
      want = peek_q.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, found);
        errors++;
      end
      if (data[31:0] !== want.seq) begin
        $error("entry_sequence: expected %h, got %h", want.seq, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.stamp) begin
        $error("entry_time: expected %h, got %h", want.stamp, data[63:32]);
        errors++;
      end
      if (data[66:64] !== want.cat) begin
        $error("entry_category: expected %0d, got %0d", want.cat, data[66:64]);
        errors++;
      end
    endfunction

    function int pending();
      return peek_q.size();
    endfunction
  endclass

  ring_scoreboard sb;

  ack_ring_event_log_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one command word, with random idle cycles ahead of it
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [CAT_W-1:0] cat,
                           logic [TIME_W-1:0] stamp, logic [SEQ_W-1:0] seq_req);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, seq_req, stamp, cat};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, cat, stamp, seq_req);
  endtask

  // Stop offering until every predicted peek word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mark target: mostly the oldest unsent entry, sometimes any slot or noise
  function automatic logic [SEQ_W-1:0] pick_mark_seq();
    result_t     oldest;
    int unsigned roll;
    oldest = sb.oldest_unsent();
    roll   = $urandom_range(99);
    if (roll < 60 && oldest.found) return oldest.seq;
    if (roll < 85) return sb.slot_seq[$urandom_range(DEPTH - 1)];
    return $urandom;
  endfunction

  // One random command; ignored code three does not count as a word
  task automatic random_word(output bit counted);
    int unsigned      roll;
    logic [CAT_W-1:0] cat;
    logic [TIME_W-1:0] stamp;
    logic [SEQ_W-1:0] seq_req;
    roll    = $urandom_range(99);
    cat     = $urandom_range(7);
    stamp   = $urandom;
    seq_req = $urandom;
    counted = 1'b1;
    if (roll < 35) begin
      send_word(CMD_RECORD, cat, stamp, seq_req);
    end else if (roll < 65) begin
      send_word(CMD_PEEK, cat, stamp, seq_req);
    end else if (roll < 92) begin
      send_word(CMD_MARK, cat, stamp, pick_mark_seq());
    end else begin
      send_word(CMD_IGNORED, cat, stamp, seq_req);
      counted = 1'b0;
    end
  endtask

  // Result side: random stall, or one long hold-off when asked
  initial begin
    m_tready <= 1'b0;
    hold_req = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    bit counted;
    int sent;
    sb            = new();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_RECORD;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty ring: peek finds nothing, mark hits only sent slots
    send_word(CMD_PEEK, 3'd0, 32'h0, 32'h0);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'h0);
    send_word(CMD_IGNORED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill past DEPTH so the first entry is overwritten
    send_word(CMD_RECORD, 3'd0, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_RECORD, 3'd7, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_RECORD, 3'd4, 32'h1234_5678, 32'h0);
    send_word(CMD_RECORD, 3'd5, 32'hA5A5_5A5A, 32'h0);
    send_word(CMD_RECORD, 3'd6, 32'h0000_0001, 32'h0);
    send_word(CMD_PEEK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Marks that miss, then out of order, then repeated
    send_word(CMD_MARK, 3'd0, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'd3);
    send_word(CMD_PEEK, 3'd0, 32'h0, 32'h0);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'd2);
    send_word(CMD_PEEK, 3'd0, 32'h0, 32'h0);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'd4);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'd4);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'd5);
    send_word(CMD_MARK, 3'd0, 32'h0, 32'd1);
    send_word(CMD_PEEK, 3'd0, 32'h0, 32'h0);
    send_word(CMD_RECORD, 3'd1, 32'h8000_0000, 32'h0);
    send_word(CMD_RECORD, 3'd2, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_RECORD, 3'd3, 32'h0F0F_F0F0, 32'h0);
    send_word(CMD_PEEK, 3'd0, 32'h0, 32'h0);

    // Long result hold-off while commands keep coming; the peeks up front
    // fill the output side so the command input stalls
    drain();
    hold_req = 1'b1;
    repeat (4) send_word(CMD_PEEK, 3'd0, 32'h0, 32'h0);
    repeat (8) random_word(counted);
    drain();

    // Random phases under different idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 16; snk_stall_pct = 16; end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        random_word(counted);
        if (counted) sent++;
      end
    end

    drain();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d peek words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
